// File: sv/csbc_pkg.sv
package csbc_pkg;

	// Byte values that matter to the lexer
	localparam logic [7:0] CharNewline   = 8'd10;
	localparam logic [7:0] CharSlash     = 8'h2F;
	localparam logic [7:0] CharStar      = 8'h2A;
	localparam logic [7:0] CharDquote    = 8'h22;
	localparam logic [7:0] CharSquote    = 8'h27;
	localparam logic [7:0] CharLbracket  = 8'h5B;
	localparam logic [7:0] CharRbracket  = 8'h5D;
	localparam logic [7:0] CharLbrace    = 8'h7B;
	localparam logic [7:0] CharRbrace    = 8'h7D;
	localparam logic [7:0] CharLparen    = 8'h28;
	localparam logic [7:0] CharRparen    = 8'h29;
	localparam logic [7:0] CharBackslash = 8'h5C;

	// Queue between classifier and lexer
	localparam int QDepth = 2;
	localparam int QPtrW  = 1;
	localparam int QCntW  = 2;

	localparam int OutCountW = 16;
	localparam int OutDataW  = 56;

	typedef enum logic [3:0] {
		CLS_OTHER,
		CLS_NEWLINE,
		CLS_SLASH,
		CLS_STAR,
		CLS_DQUOTE,
		CLS_SQUOTE,
		CLS_LBRACKET,
		CLS_RBRACKET,
		CLS_LBRACE,
		CLS_RBRACE,
		CLS_LPAREN,
		CLS_RPAREN,
		CLS_BACKSLASH
	} char_class_t;

	typedef enum logic [1:0] {
		MODE_CODE  = 2'd0,
		MODE_BLOCK = 2'd1,
		MODE_LINE  = 2'd2
	} lex_mode_t;

	// Handshake between two stages
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

endpackage

// File: sv/csbc_front.sv
module csbc_front (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,
	output csbc_pkg::char_class_t cls,
	output csbc_pkg::hs_t        q_hs_in,
	input  logic                 q_ready
);

	// Map the byte to the class the lexer acts on
	always_comb begin
		unique case (s_tdata)
			csbc_pkg::CharNewline:   cls = csbc_pkg::CLS_NEWLINE;
			csbc_pkg::CharSlash:     cls = csbc_pkg::CLS_SLASH;
			csbc_pkg::CharStar:      cls = csbc_pkg::CLS_STAR;
			csbc_pkg::CharDquote:    cls = csbc_pkg::CLS_DQUOTE;
			csbc_pkg::CharSquote:    cls = csbc_pkg::CLS_SQUOTE;
			csbc_pkg::CharLbracket:  cls = csbc_pkg::CLS_LBRACKET;
			csbc_pkg::CharRbracket:  cls = csbc_pkg::CLS_RBRACKET;
			csbc_pkg::CharLbrace:    cls = csbc_pkg::CLS_LBRACE;
			csbc_pkg::CharRbrace:    cls = csbc_pkg::CLS_RBRACE;
			csbc_pkg::CharLparen:    cls = csbc_pkg::CLS_LPAREN;
			csbc_pkg::CharRparen:    cls = csbc_pkg::CLS_RPAREN;
			csbc_pkg::CharBackslash: cls = csbc_pkg::CLS_BACKSLASH;
			default:                 cls = csbc_pkg::CLS_OTHER;
		endcase
	end

	assign s_tready      = q_ready;
	assign q_hs_in.valid = s_tvalid;
	assign q_hs_in.ready = q_ready;

endmodule

// File: sv/csbc_queue.sv
module csbc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  csbc_pkg::hs_t         hs_in,
	output logic                  in_ready,
	input  csbc_pkg::char_class_t in_cls,
	output logic                  out_valid,
	input  logic                  out_ready,
	output csbc_pkg::char_class_t out_cls
);

	csbc_pkg::char_class_t mem_q [csbc_pkg::QDepth];
	logic [csbc_pkg::QPtrW-1:0] wr_ptr_q;
	logic [csbc_pkg::QPtrW-1:0] rd_ptr_q;
	logic [csbc_pkg::QCntW-1:0] cnt_q;
	logic push;
	logic pop;

	assign in_ready  = (cnt_q != csbc_pkg::QCntW'(csbc_pkg::QDepth));
	assign out_valid = (cnt_q != '0);
	assign push      = hs_in.valid && hs_in.ready;
	assign pop       = out_valid && out_ready;
	assign out_cls   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: sv/csbc_back.sv
module csbc_back #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  csbc_pkg::char_class_t in_cls,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [csbc_pkg::OutDataW-1:0] m_tdata
);

	localparam int ExtW = (COUNT_WIDTH > csbc_pkg::OutCountW) ? COUNT_WIDTH
		: csbc_pkg::OutCountW;
	localparam logic signed [COUNT_WIDTH-1:0] CntMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CntMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	csbc_pkg::lex_mode_t mode_q, mode_d;
	logic slash_q, slash_d;
	logic star_q, star_d;
	logic esc_q, esc_d;
	logic insq_q, insq_d;
	logic indq_q, indq_d;
	logic spar_q, spar_d;
	logic dpar_q, dpar_d;
	logic signed [COUNT_WIDTH-1:0] paren_q, paren_d;
	logic signed [COUNT_WIDTH-1:0] bracket_q, bracket_d;
	logic signed [COUNT_WIDTH-1:0] brace_q, brace_d;
	logic signed [ExtW-1:0] paren_ext, bracket_ext, brace_ext;
	logic balanced;
	logic take;
	logic valid_q;
	logic [csbc_pkg::OutDataW-1:0] data_q;

	assign in_ready = !valid_q || m_tready;
	assign take     = in_valid && in_ready;

	function automatic logic signed [COUNT_WIDTH-1:0] sat_inc(
		input logic signed [COUNT_WIDTH-1:0] v
	);
		sat_inc = (v == CntMax) ? v : v + 1'b1;
	endfunction

	function automatic logic signed [COUNT_WIDTH-1:0] sat_dec(
		input logic signed [COUNT_WIDTH-1:0] v
	);
		sat_dec = (v == CntMin) ? v : v - 1'b1;
	endfunction

	// Next lexer state for the byte at the head of the queue
	always_comb begin
		logic done;
		done      = 1'b0;
		mode_d    = mode_q;
		slash_d   = slash_q;
		star_d    = star_q;
		esc_d     = esc_q;
		insq_d    = insq_q;
		indq_d    = indq_q;
		spar_d    = spar_q;
		dpar_d    = dpar_q;
		paren_d   = paren_q;
		bracket_d = bracket_q;
		brace_d   = brace_q;
		case (mode_q)
			csbc_pkg::MODE_BLOCK: begin
				if (star_q && in_cls == csbc_pkg::CLS_SLASH) begin
					mode_d = csbc_pkg::MODE_CODE;
					star_d = 1'b0;
				end else begin
					star_d = (in_cls == csbc_pkg::CLS_STAR);
				end
			end
			csbc_pkg::MODE_LINE: begin
				if (in_cls == csbc_pkg::CLS_NEWLINE) begin
					mode_d = csbc_pkg::MODE_CODE;
					insq_d = 1'b0;
					indq_d = 1'b0;
				end
			end
			default: begin
				mode_d = csbc_pkg::MODE_CODE;
				if (in_cls == csbc_pkg::CLS_NEWLINE) begin
					insq_d  = 1'b0;
					indq_d  = 1'b0;
					slash_d = 1'b0;
					esc_d   = 1'b0;
				end else if (esc_q) begin
					esc_d = 1'b0;
				end else if (indq_q) begin
					if (in_cls == csbc_pkg::CLS_DQUOTE) begin
						indq_d = 1'b0;
						dpar_d = !dpar_q;
					end
				end else if (insq_q) begin
					if (in_cls == csbc_pkg::CLS_SQUOTE) begin
						insq_d = 1'b0;
						spar_d = !spar_q;
					end
				end else begin
					if (slash_q) begin
						slash_d = 1'b0;
						if (in_cls == csbc_pkg::CLS_SLASH) begin
							mode_d = csbc_pkg::MODE_LINE;
							done   = 1'b1;
						end else if (in_cls == csbc_pkg::CLS_STAR) begin
							mode_d = csbc_pkg::MODE_BLOCK;
							star_d = 1'b0;
							done   = 1'b1;
						end
					end
					if (!done) begin
						case (in_cls)
							csbc_pkg::CLS_SLASH: slash_d = 1'b1;
							csbc_pkg::CLS_DQUOTE: begin
								indq_d = 1'b1;
								dpar_d = !dpar_q;
							end
							csbc_pkg::CLS_SQUOTE: begin
								insq_d = 1'b1;
								spar_d = !spar_q;
							end
							csbc_pkg::CLS_LBRACKET:  bracket_d = sat_inc(bracket_q);
							csbc_pkg::CLS_RBRACKET:  bracket_d = sat_dec(bracket_q);
							csbc_pkg::CLS_LBRACE:    brace_d   = sat_inc(brace_q);
							csbc_pkg::CLS_RBRACE:    brace_d   = sat_dec(brace_q);
							csbc_pkg::CLS_LPAREN:    paren_d   = sat_inc(paren_q);
							csbc_pkg::CLS_RPAREN:    paren_d   = sat_dec(paren_q);
							csbc_pkg::CLS_BACKSLASH: esc_d     = 1'b1;
							default: ;
						endcase
					end
				end
			end
		endcase
	end

	assign paren_ext   = ExtW'(paren_d);
	assign bracket_ext = ExtW'(bracket_d);
	assign brace_ext   = ExtW'(brace_d);
	assign balanced    = (paren_d == '0) && (bracket_d == '0) && (brace_d == '0)
		&& !spar_d && !dpar_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= csbc_pkg::MODE_CODE;
			slash_q   <= 1'b0;
			star_q    <= 1'b0;
			esc_q     <= 1'b0;
			insq_q    <= 1'b0;
			indq_q    <= 1'b0;
			spar_q    <= 1'b0;
			dpar_q    <= 1'b0;
			paren_q   <= '0;
			bracket_q <= '0;
			brace_q   <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (take) begin
				mode_q    <= mode_d;
				slash_q   <= slash_d;
				star_q    <= star_d;
				esc_q     <= esc_d;
				insq_q    <= insq_d;
				indq_q    <= indq_d;
				spar_q    <= spar_d;
				dpar_q    <= dpar_d;
				paren_q   <= paren_d;
				bracket_q <= bracket_d;
				brace_q   <= brace_d;
				valid_q   <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= {4'b0000,
				(mode_d != csbc_pkg::MODE_CODE),
				balanced,
				dpar_d,
				spar_d,
				brace_ext[csbc_pkg::OutCountW-1:0],
				bracket_ext[csbc_pkg::OutCountW-1:0],
				paren_ext[csbc_pkg::OutCountW-1:0]};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

// File: sv/c_source_balance_checker.sv
// A byte accepted into the class queue is registered there; the lexer takes it from the
// queue head, and its result is registered in the output register before it can leave.
// Throughput: one byte per cycle with no output stall; the lexer state register closes a loop.
// A two-entry class queue parts the classifier from the lexer, so a stalled output
// still lets up to two further bytes in before s_tready drops.
// Reset: arst_n low clears the lexer state, counts, parities, queue and output valid.
module c_source_balance_checker #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: char_in[7:0]
	input  logic [7:0]  s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: paren_count[15:0], bracket_count[31:16], brace_count[47:32],
	// single_quote_odd[48], double_quote_odd[49], all_balanced[50],
	// inside_comment[51], zero fill[55:52]
	output logic [55:0] m_tdata
);

	csbc_pkg::char_class_t front_cls;
	csbc_pkg::char_class_t head_cls;
	csbc_pkg::hs_t         q_hs_in;
	logic                  q_ready;
	logic                  head_valid;
	logic                  back_ready;

	// Front: classify each incoming byte
	csbc_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cls      (front_cls),
		.q_hs_in  (q_hs_in),
		.q_ready  (q_ready)
	);

	// Queue: hold classified bytes while the lexer stalls
	csbc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.hs_in     (q_hs_in),
		.in_ready  (q_ready),
		.in_cls    (front_cls),
		.out_valid (head_valid),
		.out_ready (back_ready),
		.out_cls   (head_cls)
	);

	// Back: advance the lexer and register the result item
	csbc_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (head_valid),
		.in_ready (back_ready),
		.in_cls   (head_cls),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: sv/csbc_checker.sv
module csbc_checker #(
	parameter int COUNT_WIDTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// An item taken while the output is empty passes the class queue and the output register, then shows up
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("accepted item did not reach the output");

	// Balanced flag agrees with the counts and parities it summarizes (checked only for COUNT_WIDTH <= 16)
	a_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (COUNT_WIDTH <= 16) |->
		(m_tdata[50] == ((m_tdata[47:0] == 48'd0) && (m_tdata[49:48] == 2'b00))))
		else $error("all_balanced inconsistent with counts");

	// Fill bits stay zero
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:52] == 4'd0)
		else $error("nonzero fill bits");

endmodule

bind c_source_balance_checker csbc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_csbc_checker (.*);
